>>> rtl/core/lmh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmh_pkg: shared definitions for the lexicographic min-heap merge block
// Default sizes, operation and error codes, the level cell command and the
// helpers that size each level of the heap.
// ----------------------------------------------------------------------------
package lmh_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int KEY_FIELDS_DEF  = 7;
  localparam int FIELD_WIDTH_DEF = 32;

  localparam int MAX_KEY_FIELDS = 7;
  localparam int PORT_KEY_W     = 32;
  localparam int SRC_W          = 8;
  localparam int TOTAL_W        = 7;
  localparam int ERR_W          = 2;
  localparam int FUNC_W         = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REPLACE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP     = 2'd2;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  // Per-level port command: one read of a sibling row, one write of a half.
  typedef struct packed {
    logic rd;
    logic wr0;
    logic wr1;
  } cell_cmd_t;

  function automatic int level_count(int capacity);
    return $clog2(capacity + 1);
  endfunction

  // Rows of sibling pairs at a level; the root level keeps one row.
  function automatic int level_rows(int level, int capacity);
    int first;
    int span;
    first = (1 << level) - 1;
    span  = capacity - first;
    if (span > (1 << level)) span = 1 << level;
    if (span < 1) span = 1;
    if (level == 0) return 1;
    return (span + 1) >> 1;
  endfunction

  function automatic int addr_bits(int rows);
    return (rows > 1) ? $clog2(rows) : 1;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/lmh_level.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmh_level: one level of the heap
// Holds the entries of one tree level as rows of sibling pairs, so a single
// registered read returns both children of a node.
// ----------------------------------------------------------------------------
module lmh_level import lmh_pkg::*; #(
  parameter int ROWS = 1,
  parameter int EW   = 232,
  parameter int RW   = 1
) (
  input  wire logic            clk,
  input  wire cell_cmd_t       cmd,
  input  wire logic [RW-1:0]   rd_row,
  input  wire logic [RW-1:0]   wr_row,
  input  wire logic [EW-1:0]   wdata,
  output logic      [2*EW-1:0] rdata
);

  localparam int AW = addr_bits(ROWS);

  logic [EW-1:0] mem0 [ROWS];
  logic [EW-1:0] mem1 [ROWS];
  logic [AW-1:0] ra;
  logic [AW-1:0] wa;

  assign ra = AW'(rd_row);
  assign wa = AW'(wr_row);

  always_ff @(posedge clk) begin
    if (cmd.wr0) mem0[wa] <= wdata;
    if (cmd.wr1) mem1[wa] <= wdata;
    // hold the last row read until the next read
    if (cmd.rd) rdata <= {mem1[ra], mem0[ra]};
  end

endmodule
`default_nettype wire

>>> rtl/core/lmh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmh_ctrl: heap sequencer
// Walks one entry up or down the chain of level cells, one level per read and
// compare, tracks the entry count and the tail slot, and holds the result.
// ----------------------------------------------------------------------------
module lmh_ctrl import lmh_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_FIELDS  = KEY_FIELDS_DEF,
  parameter int FIELD_WIDTH = FIELD_WIDTH_DEF,
  localparam int KW     = KEY_FIELDS * FIELD_WIDTH,
  localparam int EW     = KW + SRC_W,
  localparam int LEVELS = level_count(CAPACITY),
  localparam int PW     = LEVELS - 1,
  localparam int RW     = (PW > 1) ? PW - 1 : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [EW-1:0]      in_entry,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [EW-1:0]      out_entry,
  output logic      [TOTAL_W-1:0] out_total,
  output logic      [ERR_W-1:0]   out_err,
  output cell_cmd_t               cmd [LEVELS],
  output logic      [RW-1:0]      rd_row,
  output logic      [RW-1:0]      wr_row,
  output logic      [EW-1:0]      wdata,
  input  wire logic [2*EW-1:0]    rdata [LEVELS]
);

  localparam int LW  = $clog2(LEVELS + 1);
  localparam int LIW = $clog2(LEVELS);
  localparam int CW  = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP,
    S_ROOT_RD, S_ROOT_GET, S_LAST_GET, S_REPORT
  } state_t;

  function automatic logic [PW-1:0] last_pos(input logic [LW-1:0] l);
    logic [PW:0] one_hot;
    one_hot = {{PW{1'b0}}, 1'b1} << l;
    return PW'(one_hot - 1'b1);
  endfunction

  state_t            state;
  logic [FUNC_W-1:0] func_q;
  logic [EW-1:0]     new_q;
  logic [EW-1:0]     mov;
  logic [LW-1:0]     lvl;
  logic [PW-1:0]     pos;
  logic [CW-1:0]     g;
  logic [CW-1:0]     cnt;
  logic [LW-1:0]     tail_lvl;
  logic [PW-1:0]     tail_pos;
  logic              fin;
  logic [LIW-1:0]    rd_lvl_q;
  logic              half_q;
  logic [EW-1:0]     res_work;
  logic [ERR_W-1:0]  err_work;

  // memory port controls
  logic          rd_en;
  logic [LW-1:0] rd_lvl;
  logic          rd_half;
  logic          wr_en;
  logic [LW-1:0] wr_lvl;
  logic          wr_half;

  // datapath
  logic [2*EW-1:0] row;
  logic [EW-1:0]   rsel;
  logic [EW-1:0]   l_e;
  logic [EW-1:0]   r_e;
  logic [CW:0]     left;
  logic [CW:0]     right;
  logic [CW:0]     cnt_ext;
  logic            has_r;
  logic            gt_l;
  logic            gt_r;
  logic            l_lt_r;
  logic            take;
  logic            pick_r;
  logic            up_less;
  logic            dn_leaf;
  logic [PW-1:0]   ppos;
  logic [LW-1:0]   tail_lvl_inc;
  logic [PW-1:0]   tail_pos_inc;
  logic [LW-1:0]   tail_lvl_dec;
  logic [PW-1:0]   tail_pos_dec;
  logic            pop_fetch;
  logic            report_load;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    row     = rdata[rd_lvl_q];
    rsel    = half_q ? row[2*EW-1:EW] : row[EW-1:0];
    l_e     = row[EW-1:0];
    r_e     = row[2*EW-1:EW];
    left    = {g, 1'b1};
    right   = left + 1'b1;
    cnt_ext = {1'b0, cnt};
    has_r   = (right < cnt_ext);
    dn_leaf = (left >= cnt_ext);
    gt_l    = (mov[EW-1:SRC_W] > l_e[EW-1:SRC_W]);
    gt_r    = (mov[EW-1:SRC_W] > r_e[EW-1:SRC_W]);
    l_lt_r  = (l_e[EW-1:SRC_W] < r_e[EW-1:SRC_W]);
    take    = has_r ? (gt_l || gt_r) : gt_l;
    pick_r  = has_r && !l_lt_r;
    up_less = (mov[EW-1:SRC_W] < rsel[EW-1:SRC_W]);
    ppos    = pos >> 1;
  end

  // tail slot, the index equal to the entry count
  always_comb begin
    if (tail_pos == last_pos(tail_lvl)) begin
      tail_lvl_inc = tail_lvl + 1'b1;
      tail_pos_inc = '0;
    end else begin
      tail_lvl_inc = tail_lvl;
      tail_pos_inc = tail_pos + 1'b1;
    end
    if (tail_pos == '0) begin
      tail_lvl_dec = tail_lvl - 1'b1;
      tail_pos_dec = last_pos(tail_lvl - 1'b1);
    end else begin
      tail_lvl_dec = tail_lvl;
      tail_pos_dec = tail_pos - 1'b1;
    end
  end

  assign pop_fetch   = (state == S_ROOT_GET) && !fin && (func_q == FUNC_POP);
  assign report_load = (state == S_REPORT) && (!out_valid || out_ready);

  always_comb begin
    rd_en   = 1'b0;
    rd_lvl  = '0;
    rd_row  = '0;
    rd_half = 1'b0;
    wr_en   = 1'b0;
    wr_lvl  = lvl;
    wr_row  = RW'(pos >> 1);
    wr_half = pos[0];
    wdata   = mov;
    unique case (state)
      S_UP_RD: begin
        if (lvl == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_lvl  = lvl - 1'b1;
          rd_row  = RW'(ppos >> 1);
          rd_half = ppos[0];
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        wdata = up_less ? rsel : mov;
      end
      S_DN_RD: begin
        if (dn_leaf) begin
          wr_en = 1'b1;
        end else begin
          rd_en  = 1'b1;
          rd_lvl = lvl + 1'b1;
          rd_row = RW'(pos);
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        wdata = take ? (pick_r ? r_e : l_e) : mov;
      end
      S_ROOT_RD: begin
        rd_en = 1'b1;
      end
      S_ROOT_GET: begin
        if (pop_fetch) begin
          rd_en   = 1'b1;
          rd_lvl  = tail_lvl_dec;
          rd_row  = RW'(tail_pos_dec >> 1);
          rd_half = tail_pos_dec[0];
        end
      end
      S_IDLE, S_LAST_GET, S_REPORT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      cmd[k].rd  = rd_en && (rd_lvl == LW'(k));
      cmd[k].wr0 = wr_en && (wr_lvl == LW'(k)) && !wr_half;
      cmd[k].wr1 = wr_en && (wr_lvl == LW'(k)) && wr_half;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      tail_lvl  <= '0;
      tail_pos  <= '0;
      fin       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_lvl_q <= LIW'(rd_lvl);
        half_q   <= rd_half;
      end
      if (report_load) begin
        out_valid <= 1'b1;
        out_entry <= res_work;
        out_err   <= err_work;
        out_total <= TOTAL_W'(cnt);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q   <= in_func;
            new_q    <= in_entry;
            fin      <= 1'b0;
            err_work <= ERR_OK;
            unique case (in_func) inside
              FUNC_INSERT: begin
                if (cnt == CW'(CAPACITY)) begin
                  err_work <= ERR_FULL;
                  fin      <= 1'b1;
                  state    <= S_ROOT_RD;
                end else begin
                  mov      <= in_entry;
                  lvl      <= tail_lvl;
                  pos      <= tail_pos;
                  cnt      <= cnt + 1'b1;
                  tail_lvl <= tail_lvl_inc;
                  tail_pos <= tail_pos_inc;
                  state    <= S_UP_RD;
                end
              end
              FUNC_REPLACE, FUNC_POP: begin
                if (cnt == '0) begin
                  err_work <= ERR_EMPTY;
                  res_work <= '0;
                  state    <= S_REPORT;
                end else begin
                  state <= S_ROOT_RD;
                end
              end
              default: begin
                if (cnt == '0) begin
                  res_work <= '0;
                  state    <= S_REPORT;
                end else begin
                  fin   <= 1'b1;
                  state <= S_ROOT_RD;
                end
              end
            endcase
          end
        end
        S_UP_RD: begin
          if (lvl == '0) begin
            fin   <= 1'b1;
            state <= S_ROOT_RD;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (up_less) begin
            lvl   <= lvl - 1'b1;
            pos   <= ppos;
            state <= S_UP_RD;
          end else begin
            fin   <= 1'b1;
            state <= S_ROOT_RD;
          end
        end
        S_DN_RD: begin
          if (dn_leaf) begin
            fin   <= 1'b1;
            state <= (func_q == FUNC_POP) ? S_REPORT : S_ROOT_RD;
          end else begin
            state <= S_DN_CMP;
          end
        end
        S_DN_CMP: begin
          if (take) begin
            lvl   <= lvl + 1'b1;
            pos   <= PW'({pos, pick_r});
            g     <= CW'(pick_r ? right : left);
            state <= S_DN_RD;
          end else begin
            fin   <= 1'b1;
            state <= (func_q == FUNC_POP) ? S_REPORT : S_ROOT_RD;
          end
        end
        S_ROOT_RD: begin
          state <= S_ROOT_GET;
        end
        S_ROOT_GET: begin
          if (fin) begin
            res_work <= rsel;
            state    <= S_REPORT;
          end else if (func_q == FUNC_REPLACE) begin
            // new key under the root's own source tag
            mov   <= {new_q[EW-1:SRC_W], rsel[SRC_W-1:0]};
            lvl   <= '0;
            pos   <= '0;
            g     <= '0;
            state <= S_DN_RD;
          end else begin
            res_work <= rsel;
            cnt      <= cnt - 1'b1;
            tail_lvl <= tail_lvl_dec;
            tail_pos <= tail_pos_dec;
            state    <= S_LAST_GET;
          end
        end
        S_LAST_GET: begin
          mov   <= rsel;
          lvl   <= '0;
          pos   <= '0;
          g     <= '0;
          state <= S_DN_RD;
        end
        S_REPORT: begin
          if (report_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en && (rd_lvl == wr_lvl)))
    else $error("read and write on the same level cell");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_func == FUNC_INSERT) && (cnt != CW'(CAPACITY)))
    |=> (cnt == $past(cnt) + 1'b1))
    else $error("insert did not grow the heap");

  a_pos_in_level: assert property (@(posedge clk) disable iff (rst)
    ((state == S_UP_CMP) || (state == S_DN_CMP)) |-> (pos <= last_pos(lvl)))
    else $error("walk position outside its level");
`endif

endmodule
`default_nettype wire

>>> rtl/core/lexicographic_min_heap_merge_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lexicographic_min_heap_merge_top: min-heap priority queue for k-way merge
// Binary min-heap of source-tagged entries with lexicographic multi-field keys.
// ----------------------------------------------------------------------------
// The heap is stored as a chain of level cells, one per tree level (L levels,
// L = ceil(log2(CAPACITY+1)), 7 at 64 entries); each cell keeps its level as
// rows of sibling pairs so one read returns both children. A sequencer walks
// the moving entry through the chain, one level per registered read plus one
// compare. A replace or pop on an empty heap (or code 3 on an empty heap)
// goes straight to the result; an insert into a full heap or code 3 on a
// filled heap reads the root and reports it; an insert climbs from the tail
// slot toward the root and then reads the root; a pop reads the root, then
// the last entry, and sinks that toward a leaf; a replace reads the root,
// sinks the new key toward a leaf and then reads the root. One item is worked
// on at a time; in_ready is high only while the sequencer is idle, which it
// returns to as the result is loaded. The result register frees the input
// side: a new transaction is taken while the previous result still waits for
// out_ready. Keys compare with key_0 most significant; only the first
// KEY_FIELDS fields, each cut to FIELD_WIDTH bits, take part, and unused
// output key fields read as zero. Insert into a full heap reports the current
// minimum with error 1; replace or pop on an empty heap reports all-zero
// fields with error 2. Entry storage has no reset; only the entry count and
// control state clear on rst.
// ----------------------------------------------------------------------------
module lexicographic_min_heap_merge_top import lmh_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_FIELDS  = KEY_FIELDS_DEF,
  parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FUNC_W-1:0]     func,
  input  wire logic [SRC_W-1:0]      source_tag,
  input  wire logic [PORT_KEY_W-1:0] key_0,
  input  wire logic [PORT_KEY_W-1:0] key_1,
  input  wire logic [PORT_KEY_W-1:0] key_2,
  input  wire logic [PORT_KEY_W-1:0] key_3,
  input  wire logic [PORT_KEY_W-1:0] key_4,
  input  wire logic [PORT_KEY_W-1:0] key_5,
  input  wire logic [PORT_KEY_W-1:0] key_6,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [SRC_W-1:0]      out_source,
  output logic      [PORT_KEY_W-1:0] out_key_0,
  output logic      [PORT_KEY_W-1:0] out_key_1,
  output logic      [PORT_KEY_W-1:0] out_key_2,
  output logic      [PORT_KEY_W-1:0] out_key_3,
  output logic      [PORT_KEY_W-1:0] out_key_4,
  output logic      [PORT_KEY_W-1:0] out_key_5,
  output logic      [PORT_KEY_W-1:0] out_key_6,
  output logic      [TOTAL_W-1:0]    entry_total,
  output logic      [ERR_W-1:0]      error_code
);

  localparam int KW     = KEY_FIELDS * FIELD_WIDTH;
  localparam int EW     = KW + SRC_W;
  localparam int LEVELS = level_count(CAPACITY);
  localparam int PW     = LEVELS - 1;
  localparam int RW     = (PW > 1) ? PW - 1 : 1;

  logic [PORT_KEY_W-1:0] key_in  [MAX_KEY_FIELDS];
  logic [PORT_KEY_W-1:0] key_out [MAX_KEY_FIELDS];
  logic [EW-1:0]         in_entry;
  logic [EW-1:0]         res_entry;

  cell_cmd_t       cell_cmd   [LEVELS];
  logic [2*EW-1:0] cell_rdata [LEVELS];
  logic [RW-1:0]   rd_row;
  logic [RW-1:0]   wr_row;
  logic [EW-1:0]   wdata;

  assign key_in[0] = key_0;
  assign key_in[1] = key_1;
  assign key_in[2] = key_2;
  assign key_in[3] = key_3;
  assign key_in[4] = key_4;
  assign key_in[5] = key_5;
  assign key_in[6] = key_6;

  // Pack the key as one wide word, field 0 on top, so a plain unsigned
  // compare of the word orders entries lexicographically.
  always_comb begin
    in_entry              = '0;
    in_entry[SRC_W-1:0]   = source_tag;
    for (int f = 0; f < KEY_FIELDS; f++) begin
      in_entry[EW-1-f*FIELD_WIDTH -: FIELD_WIDTH] = key_in[f][FIELD_WIDTH-1:0];
    end
  end

  // Unpack the reported entry; fields past KEY_FIELDS stay zero.
  always_comb begin
    for (int f = 0; f < MAX_KEY_FIELDS; f++) begin
      key_out[f] = '0;
      if (f < KEY_FIELDS) begin
        key_out[f][FIELD_WIDTH-1:0] = res_entry[EW-1-f*FIELD_WIDTH -: FIELD_WIDTH];
      end
    end
  end

  assign out_source = res_entry[SRC_W-1:0];
  assign out_key_0  = key_out[0];
  assign out_key_1  = key_out[1];
  assign out_key_2  = key_out[2];
  assign out_key_3  = key_out[3];
  assign out_key_4  = key_out[4];
  assign out_key_5  = key_out[5];
  assign out_key_6  = key_out[6];

  // Sequencer: walk entries through the level chain and hold the result.
  lmh_ctrl #(
    .CAPACITY    (CAPACITY),
    .KEY_FIELDS  (KEY_FIELDS),
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (func),
    .in_entry  (in_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_entry (res_entry),
    .out_total (entry_total),
    .out_err   (error_code),
    .cmd       (cell_cmd),
    .rd_row    (rd_row),
    .wr_row    (wr_row),
    .wdata     (wdata),
    .rdata     (cell_rdata)
  );

  // Chain of level cells: level k holds heap indices 2^k-1 .. 2^(k+1)-2.
  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    lmh_level #(
      .ROWS (level_rows(k, CAPACITY)),
      .EW   (EW),
      .RW   (RW)
    ) u_level (
      .clk    (clk),
      .cmd    (cell_cmd[k]),
      .rd_row (rd_row),
      .wr_row (wr_row),
      .wdata  (wdata),
      .rdata  (cell_rdata[k])
    );
  end

endmodule
`default_nettype wire
